// ===== sv/yuyv_rgb_pkg.sv =====
package yuyv_rgb_pkg;

  // Byte positions inside one packed group.
  localparam logic [1:0] PhaseY0 = 2'd0;
  localparam logic [1:0] PhaseV  = 2'd1;
  localparam logic [1:0] PhaseY1 = 2'd2;
  localparam logic [1:0] PhaseU  = 2'd3;

  // Group queue between the byte front end and the conversion back end.
  localparam int QDepth = 2;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  // Signed width of every product and sum in the color matrix.
  localparam int SumW = 20;
  typedef logic signed [SumW-1:0] sum_t;

  localparam sum_t CoefY  = 20'sd298;
  localparam sum_t CoefRv = 20'sd409;
  localparam sum_t CoefGu = 20'sd100;
  localparam sum_t CoefGv = 20'sd208;
  localparam sum_t CoefBu = 20'sd516;
  localparam sum_t Round  = 20'sd128;
  localparam logic signed [9:0] LumaOfs   = 10'sd16;
  localparam logic signed [9:0] ChromaOfs = 10'sd128;

  typedef struct packed {
    logic [7:0] y0;
    logic [7:0] y1;
    logic [7:0] u;
    logic [7:0] v;
    logic       frame_end;
  } group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Floor shift by eight and saturate to one unsigned byte.
  function automatic logic [7:0] clamp_pix(sum_t s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'd0;
    end else if (|s[SumW-2:16]) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

endpackage

// ===== sv/yuyv_rgb_front.sv =====
module yuyv_rgb_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_frame_end,
  input  yuyv_rgb_pkg::q_stat_t q_stat,
  output logic                  q_push,
  output yuyv_rgb_pkg::group_t  q_wdata
);
  import yuyv_rgb_pkg::*;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] y0_r, v_r, y1_r;
  logic       in_acc;

  // Only the fourth byte needs room in the queue.
  assign in_ready = !((phase_r == PhaseU) && q_stat.full);
  assign in_acc   = in_valid && in_ready;
  assign q_push   = in_acc && (phase_r == PhaseU);

  assign q_wdata.y0        = y0_r;
  assign q_wdata.y1        = y1_r;
  assign q_wdata.u         = in_data_byte;
  assign q_wdata.v         = v_r;
  assign q_wdata.frame_end = in_frame_end;

  always_comb begin
    if (in_frame_end) begin
      phase_nxt = PhaseY0;
    end else begin
      phase_nxt = phase_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PhaseY0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      unique case (phase_r)
        PhaseY0: y0_r <= in_data_byte;
        PhaseV:  v_r  <= in_data_byte;
        PhaseY1: y1_r <= in_data_byte;
        PhaseU:  ;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/yuyv_rgb_queue.sv =====
module yuyv_rgb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  yuyv_rgb_pkg::group_t  wdata,
  input  logic                  pop,
  output yuyv_rgb_pkg::group_t  rdata,
  output yuyv_rgb_pkg::q_stat_t stat
);
  import yuyv_rgb_pkg::*;

  group_t           mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == QCntW'(QDepth));
  assign stat.empty = (cnt_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/yuyv_rgb_back.sv =====
module yuyv_rgb_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  yuyv_rgb_pkg::group_t  q_rdata,
  input  yuyv_rgb_pkg::q_stat_t q_stat,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_pair_last,
  output logic                  out_frame_last
);
  import yuyv_rgb_pkg::*;

  logic             sel_r, s1_valid_r, out_valid_r;
  logic             out_adv, s1_adv, s1_load;
  logic [7:0]       y_sel;
  logic signed [9:0] y_off, d_off, e_off;
  sum_t             c_r, rv_r, g_r, bu_r;
  sum_t             c_nxt, rv_nxt, g_nxt, bu_nxt;
  logic             pair_r, flast_r;
  sum_t             r_sum, g_sum, b_sum;
  logic [7:0]       red_r, green_r, blue_r;
  logic             out_pair_r, out_flast_r;

  assign out_adv = !out_valid_r || out_ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign s1_load = !q_stat.empty && s1_adv;
  // A group leaves the queue once its second pixel enters the multiplier stage.
  assign q_pop   = s1_load && sel_r;

  always_comb begin
    y_sel  = sel_r ? q_rdata.y1 : q_rdata.y0;
    y_off  = $signed({2'b00, y_sel}) - LumaOfs;
    d_off  = $signed({2'b00, q_rdata.u}) - ChromaOfs;
    e_off  = $signed({2'b00, q_rdata.v}) - ChromaOfs;
    c_nxt  = sum_t'(y_off) * CoefY;
    rv_nxt = sum_t'(e_off) * CoefRv;
    g_nxt  = -(sum_t'(d_off) * CoefGu) - (sum_t'(e_off) * CoefGv);
    bu_nxt = sum_t'(d_off) * CoefBu;
    r_sum  = c_r + rv_r + Round;
    g_sum  = c_r + g_r + Round;
    b_sum  = c_r + bu_r + Round;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= 1'b0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= !q_stat.empty;
      end
      if (s1_load) begin
        sel_r <= !sel_r;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      c_r     <= c_nxt;
      rv_r    <= rv_nxt;
      g_r     <= g_nxt;
      bu_r    <= bu_nxt;
      pair_r  <= sel_r;
      flast_r <= sel_r && q_rdata.frame_end;
    end
    if (out_adv && s1_valid_r) begin
      red_r       <= clamp_pix(r_sum);
      green_r     <= clamp_pix(g_sum);
      blue_r      <= clamp_pix(b_sum);
      out_pair_r  <= pair_r;
      out_flast_r <= flast_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_pair_last  = out_pair_r;
  assign out_frame_last = out_flast_r;

endmodule

// ===== sv/packed_yuyv_to_rgb_stream_core.sv =====
// The first pixel of a group passes the queue, the multiplier register and the
// output register after its fourth byte is accepted; the second pixel follows.
// One byte per cycle in, one pixel per cycle out while out_ready is high.
// Input stalls only when a fourth byte meets a full two-group queue.
// Reset (rst_n low, synchronous) returns the byte phase to the first luma byte,
// empties the queue and drops any pixel in flight.
module packed_yuyv_to_rgb_stream_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_pair_last,
  output logic       out_frame_last
);
  import yuyv_rgb_pkg::*;

  // The front end gathers the four bytes of a group (Y0, V, Y1, U) and pushes
  // one complete group word into the queue when U arrives. A frame end on any
  // earlier byte simply rewinds the phase, so a partial group is dropped.
  group_t  q_wdata, q_rdata;
  q_stat_t q_stat;
  logic    q_push, q_pop;

  yuyv_rgb_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_wdata      (q_wdata)
  );

  // The queue decouples the byte side from the pixel side, so an output stall
  // does not stop bytes until two whole groups are waiting.
  yuyv_rgb_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // The back end converts each group into two pixels: a multiplier stage forms
  // the BT.601 products, then an add, round, shift and clamp stage feeds the
  // output register.
  yuyv_rgb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_rdata        (q_rdata),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_pair_last  (out_pair_last),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== sv/yuyv_rgb_checker.sv =====
module yuyv_rgb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_pair_last,
  input logic       out_frame_last
);

  // Set after the first pixel of a pair has been taken.
  logic half_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      half_r <= !half_r;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_pair_last) && $stable(out_frame_last))
    else $error("stalled pixel word changed");

  a_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |-> out_pair_last == half_r)
    else $error("pixels do not alternate first and second of a pair");

  a_flast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_frame_last || out_pair_last)
    else $error("frame end flagged on a first pixel");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("pixel word valid right after reset");

endmodule

bind packed_yuyv_to_rgb_stream_core yuyv_rgb_checker u_chk (.*);

// ===== tb/sv/packed_yuyv_to_rgb_stream_core_test.sv =====
`timescale 1ns / 100ps

module packed_yuyv_to_rgb_stream_core_test;
  import yuyv_rgb_pkg::*;

  // Cycles with no accepted word on either channel before the run is abandoned.
  // The longest legal quiet stretch is the deliberate output hold-off below.
  localparam int QuietLimit = 4000;
  // Output hold-off used to fill the group queue and stall the byte input.
  localparam int HoldCycles = 300;
  // Cycles allowed after the last expected pixel for stray output to appear.
  localparam int DrainCycles = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_last;
    logic       frame_last;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_frame_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_pair_last;
  logic       out_frame_last;

  // Predictor state: where the next byte lands in its group and what the
  // group has collected so far.
  logic [1:0] group_pos = PhaseY0;
  logic [7:0] luma_first = 8'd0;
  logic [7:0] chroma_v = 8'd0;
  logic [7:0] luma_second = 8'd0;

  pixel_t pending_pixels[$];
  int     error_count = 0;
  int     quiet_cycles = 0;

  // Traffic shaping, changed by the test sequence between phases.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int hold_left = 0;

  packed_yuyv_to_rgb_stream_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_frame_end  (in_frame_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_pair_last (out_pair_last),
    .out_frame_last(out_frame_last)
  );

  always #4 clk = ~clk;

  // Floor shift by eight, then saturate to one byte. A negative sum always
  // floors to a negative value, so it goes straight to zero.
  function automatic logic [7:0] saturate(int acc);
    int scaled;
    if (acc < 0) begin
      return 8'd0;
    end
    scaled = acc >>> 8;
    if (scaled > 255) begin
      return 8'd255;
    end
    return scaled[7:0];
  endfunction

  // BT.601 integer conversion of one pixel with its shared chroma pair.
  function automatic pixel_t to_rgb(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                    logic second, logic frame_tail);
    int     luma_term;
    int     cb;
    int     cr;
    pixel_t px;
    luma_term = 298 * (int'(y) - 16);
    cb = int'(u) - 128;
    cr = int'(v) - 128;
    px.red = saturate(luma_term + 409 * cr + 128);
    px.green = saturate(luma_term - 100 * cb - 208 * cr + 128);
    px.blue = saturate(luma_term + 516 * cb + 128);
    px.pair_last = second;
    px.frame_last = frame_tail;
    return px;
  endfunction

  // Advance the predictor by one accepted byte. Only the U byte, the last of
  // the group, releases pixels; a frame end anywhere else drops the partial
  // group. Either way a frame end puts the next byte back at first luma.
  function automatic void predict_byte(logic [7:0] b, logic fe);
    case (group_pos)
      PhaseY0: luma_first = b;
      PhaseV:  chroma_v = b;
      PhaseY1: luma_second = b;
      PhaseU: begin
        pending_pixels.push_back(to_rgb(luma_first, b, chroma_v, 1'b0, 1'b0));
        pending_pixels.push_back(to_rgb(luma_second, b, chroma_v, 1'b1, fe));
      end
      default: ;
    endcase
    group_pos = fe ? PhaseY0 : group_pos + 2'd1;
  endfunction

  // Byte side monitor: every accepted word feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      predict_byte(in_data_byte, in_frame_end);
    end
  end

  // Pixel side checker: each accepted pixel is compared with the oldest
  // prediction, field by field.
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel with nothing predicted: rgb %0d %0d %0d", out_red, out_green,
               out_blue);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_red !== want.red) begin
          $error("red mismatch: expected %0d, got %0d", want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("green mismatch: expected %0d, got %0d", want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue mismatch: expected %0d, got %0d", want.blue, out_blue);
          error_count++;
        end
        if (out_pair_last !== want.pair_last) begin
          $error("pair_last mismatch: expected %0d, got %0d", want.pair_last,
                 out_pair_last);
          error_count++;
        end
        if (out_frame_last !== want.frame_last) begin
          $error("frame_last mismatch: expected %0d, got %0d", want.frame_last,
                 out_frame_last);
          error_count++;
        end
      end
    end
  end

  // Receiver. A requested hold-off is counted down here, one cycle per
  // falling edge; otherwise ready drops at random by the current stall rate.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Watchdog: a run that stops moving words on both channels is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("packed_yuyv_to_rgb_stream_core_test NOT OK");
      $finish;
    end
  end

  // Offer one byte and return at the rising edge that accepts it. Idle
  // cycles come first, so valid is only lowered between words and never in
  // the same step that raises it again.
  task automatic send_byte(logic [7:0] b, logic fe);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_frame_end <= fe;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_group(logic [7:0] y0, logic [7:0] v, logic [7:0] y1,
                            logic [7:0] u, logic fe);
    send_byte(y0, 1'b0);
    send_byte(v, 1'b0);
    send_byte(y1, 1'b0);
    send_byte(u, fe);
  endtask

  // Corner groups: black and white levels, full chroma swings both ways so
  // every channel clamps at both ends, and a frame end on each byte position.
  task automatic test_directed_groups();
    send_group(8'd16, 8'd128, 8'd235, 8'd128, 1'b0);
    send_group(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    send_group(8'd0, 8'd255, 8'd255, 8'd0, 1'b0);
    // A frame that ends on its first luma byte, then on V, then on second luma:
    // each partial group is thrown away and the phase restarts.
    send_byte(8'hAA, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hEB, 1'b1);
    // Frame end on the U byte tags the second pixel.
    send_group(8'd81, 8'd240, 8'd145, 8'd90, 1'b1);
  endtask

  // Mostly whole frames of a few groups with random bytes. About one frame in
  // ten is cut short at a random byte, and about one in ten runs on without a
  // frame end so that the phase carries into the next frame.
  task automatic test_random_frames(int byte_budget);
    int sent;
    int groups;
    int cut;
    int kind;
    logic close_frame;
    sent = 0;
    while (sent < byte_budget) begin
      groups = $urandom_range(1, 6);
      kind = $urandom_range(9);
      cut = groups * 4;
      close_frame = 1'b1;
      if (kind == 0) begin
        cut = $urandom_range(1, groups * 4);
      end else if (kind == 1) begin
        close_frame = 1'b0;
      end
      for (int i = 1; i <= cut; i++) begin
        send_byte(8'($urandom_range(255)), close_frame && (i == cut));
        sent++;
      end
    end
  endtask

  // Hold the pixel side off for a long stretch while bytes keep coming, so
  // the group queue fills and the byte input has to stall.
  task automatic test_output_hold();
    sender_idle_pct = 0;
    hold_left = HoldCycles;
    for (int i = 0; i < 40; i++) begin
      send_byte(8'($urandom_range(255)), i == 39);
    end
  endtask

  task automatic set_traffic(int idle_pct, int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    set_traffic(0, 0);
    test_directed_groups();
    test_random_frames(440);

    set_traffic(78, 0);
    test_random_frames(420);

    set_traffic(0, 78);
    test_random_frames(420);

    set_traffic(15, 15);
    test_random_frames(420);

    test_output_hold();

    set_traffic(15, 15);
    test_random_frames(60);

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain everything still predicted, then give the block a few more cycles
    // to show any pixel it should not produce. The watchdog bounds this wait.
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (error_count == 0) begin
      $display("packed_yuyv_to_rgb_stream_core_test OK");
    end else begin
      $display("packed_yuyv_to_rgb_stream_core_test NOT OK");
    end
    $finish;
  end

endmodule
